>>> rtl/cpcr_pkg.sv
// Shared types for the circle pair collision resolver.
`default_nettype none

package cpcr_pkg;

  // Largest value of the 47-bit energy result.
  localparam logic [46:0] ENERGY_MAX = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [23:0] a_pos_x;
    logic signed [23:0] a_pos_y;
    logic signed [23:0] a_vel_x;
    logic signed [23:0] a_vel_y;
    logic        [23:0] a_inv_mass;
    logic        [21:0] a_radius;
    logic signed [23:0] b_pos_x;
    logic signed [23:0] b_pos_y;
    logic signed [23:0] b_vel_x;
    logic signed [23:0] b_vel_y;
    logic        [23:0] b_inv_mass;
    logic        [21:0] b_radius;
  } cpcr_in_t;

  // One classified disc pair, as it travels from the front end to the solver.
  typedef struct packed {
    logic signed [23:0] pax;
    logic signed [23:0] pay;
    logic signed [23:0] vax;
    logic signed [23:0] vay;
    logic signed [23:0] pbx;
    logic signed [23:0] pby;
    logic signed [23:0] vbx;
    logic signed [23:0] vby;
    logic        [23:0] wa;
    logic        [23:0] wb;
    logic        [24:0] wsum;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dvx;
    logic signed [24:0] dvy;
    logic        [22:0] rsum;
    logic        [48:0] dist2;
    logic               contact;
    logic               resolve;
    logic        [46:0] energy;
  } cpcr_item_t;

endpackage

`default_nettype wire

>>> rtl/cpcr_front.sv
// Front end: takes disc pairs, forms differences and squares, flags contact.
`default_nettype none

module cpcr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cpcr_pkg::cpcr_in_t   in_data,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output cpcr_pkg::cpcr_item_t      q_item
);
  import cpcr_pkg::*;

  typedef struct packed {
    logic [47:0] dxx;
    logic [47:0] dyy;
    logic [45:0] rr;
    logic [47:0] e0;
    logic [47:0] e1;
    logic [47:0] e2;
    logic [47:0] e3;
  } sq_t;

  function automatic logic [47:0] sqr25(input logic signed [24:0] a);
    logic signed [49:0] p;
    p = 50'(a) * 50'(a);
    return p[47:0];
  endfunction

  cpcr_item_t f1_r, f2_r, f3_r;
  cpcr_item_t f3_nxt;
  sq_t        sq_r;
  logic [2:0] v_r;
  logic       en;
  logic [48:0] dist2;
  logic [48:0] esum;
  logic        contact;

  assign en       = !v_r[2] || q_ready;
  assign in_ready = en;
  assign q_valid  = v_r[2];
  assign q_item   = f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r.pax     <= in_data.a_pos_x;
      f1_r.pay     <= in_data.a_pos_y;
      f1_r.vax     <= in_data.a_vel_x;
      f1_r.vay     <= in_data.a_vel_y;
      f1_r.pbx     <= in_data.b_pos_x;
      f1_r.pby     <= in_data.b_pos_y;
      f1_r.vbx     <= in_data.b_vel_x;
      f1_r.vby     <= in_data.b_vel_y;
      f1_r.wa      <= in_data.a_inv_mass;
      f1_r.wb      <= in_data.b_inv_mass;
      f1_r.wsum    <= 25'(in_data.a_inv_mass) + 25'(in_data.b_inv_mass);
      f1_r.dx      <= 25'(in_data.a_pos_x) - 25'(in_data.b_pos_x);
      f1_r.dy      <= 25'(in_data.a_pos_y) - 25'(in_data.b_pos_y);
      f1_r.dvx     <= 25'(in_data.a_vel_x) - 25'(in_data.b_vel_x);
      f1_r.dvy     <= 25'(in_data.a_vel_y) - 25'(in_data.b_vel_y);
      f1_r.rsum    <= 23'(in_data.a_radius) + 23'(in_data.b_radius);
      f1_r.dist2   <= '0;
      f1_r.contact <= 1'b0;
      f1_r.resolve <= 1'b0;
      f1_r.energy  <= '0;

      f2_r    <= f1_r;
      sq_r.dxx <= sqr25(f1_r.dx);
      sq_r.dyy <= sqr25(f1_r.dy);
      sq_r.rr  <= {23'd0, f1_r.rsum} * {23'd0, f1_r.rsum};
      sq_r.e0  <= sqr25(25'(f1_r.vax));
      sq_r.e1  <= sqr25(25'(f1_r.vay));
      sq_r.e2  <= sqr25(25'(f1_r.vbx));
      sq_r.e3  <= sqr25(25'(f1_r.vby));

      f3_r <= f3_nxt;
    end
  end

  always_comb begin
    dist2   = 49'(sq_r.dxx) + 49'(sq_r.dyy);
    esum    = 49'(sq_r.e0) + 49'(sq_r.e1) + 49'(sq_r.e2) + 49'(sq_r.e3);
    contact = dist2 <= {3'd0, sq_r.rr};

    f3_nxt         = f2_r;
    f3_nxt.dist2   = dist2;
    f3_nxt.contact = contact;
    f3_nxt.resolve = contact && (f2_r.wsum != '0);
    f3_nxt.energy  = !contact ? '0 :
                     (esum > {2'd0, ENERGY_MAX}) ? ENERGY_MAX : esum[46:0];
  end

endmodule

`default_nettype wire

>>> rtl/cpcr_queue.sv
// Short queue that decouples the front end from the solver pipeline.
`default_nettype none

module cpcr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cpcr_pkg::cpcr_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cpcr_pkg::cpcr_item_t      out_item
);
  import cpcr_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  cpcr_item_t       mem_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  cnt_r;
  logic             push, pop;

  assign in_ready  = cnt_r != Q_CW'(Q_DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH)) else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    Q_AW'(wr_ptr_r - rd_ptr_r) == cnt_r[Q_AW-1:0]) else $error("queue pointers off");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count lost a transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/cpcr_back.sv
// Solver pipeline: square root, normal and share division, impulse, update.
`default_nettype none

module cpcr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire cpcr_pkg::cpcr_item_t q_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cpcr_pkg::cpcr_item_t      out_item
);
  import cpcr_pkg::*;

  // Stage schedule. Several steps run side by side on different fields.
  localparam int SQ_STEPS = 25;
  localparam int K_DEPTH  = 25;
  localparam int K_ND0    = 26;
  localparam int ND_STEPS = 17;
  localparam int K_SHMUL  = 26;
  localparam int K_SHINIT = 27;
  localparam int K_SD0    = 28;
  localparam int SD_STEPS = 23;
  localparam int K_NFIN   = 43;
  localparam int K_SMUL   = 44;
  localparam int K_SSUM   = 45;
  localparam int K_M      = 46;
  localparam int K_KMUL   = 47;
  localparam int K_KINIT  = 48;
  localparam int K_KD0    = 49;
  localparam int KD_STEPS = 27;
  localparam int K_PMUL   = 51;
  localparam int K_PADD   = 52;
  localparam int K_VMUL   = 76;
  localparam int K_VADD   = 77;
  localparam int N_BACK   = 78;

  typedef struct packed {
    cpcr_item_t         it;
    logic        [49:0] sq_rem;
    logic        [24:0] root;
    logic        [22:0] depth;
    logic        [41:0] nrem_x;
    logic        [41:0] nrem_y;
    logic        [16:0] nq_x;
    logic        [16:0] nq_y;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic        [47:0] srem_a;
    logic        [47:0] srem_b;
    logic        [22:0] shq_a;
    logic        [22:0] shq_b;
    logic signed [42:0] sp_x;
    logic signed [42:0] sp_y;
    logic signed [43:0] sfull;
    logic        [26:0] m;
    logic        [51:0] krem_a;
    logic        [51:0] krem_b;
    logic        [26:0] kq_a;
    logic        [26:0] kq_b;
    logic signed [41:0] pp_ax;
    logic signed [41:0] pp_ay;
    logic signed [41:0] pp_bx;
    logic signed [41:0] pp_by;
    logic signed [25:0] npax;
    logic signed [25:0] npay;
    logic signed [25:0] npbx;
    logic signed [25:0] npby;
    logic signed [45:0] vp_ax;
    logic signed [45:0] vp_ay;
    logic signed [45:0] vp_bx;
    logic signed [45:0] vp_by;
  } bk_t;

  // Divide by 2^16, rounding to nearest with ties away from zero.
  function automatic logic signed [29:0] rnd16(input logic signed [45:0] p);
    logic [45:0] mag;
    logic [45:0] q;
    mag = p[45] ? 46'(-p) : 46'(p);
    q   = (mag + 46'd32768) >> 16;
    return p[45] ? -$signed(q[29:0]) : $signed(q[29:0]);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic [24:0] abs25(input logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  function automatic bk_t bk_load(input cpcr_item_t q);
    bk_t y;
    y        = '0;
    y.it     = q;
    y.sq_rem = {1'b0, q.dist2};
    return y;
  endfunction

  function automatic bk_t bk_step(input int k, input bk_t x);
    bk_t         y;
    int          i;
    logic [51:0] tr;
    logic [41:0] dn;
    logic [47:0] ds;
    logic [51:0] dk;
    logic [43:0] smag;
    logic [43:0] t;
    logic [16:0] cq;
    y = x;

    // Square root, one result bit per stage.
    if (k < SQ_STEPS) begin
      i  = SQ_STEPS - 1 - k;
      tr = ({27'd0, x.root} << (i + 1)) + (52'd1 << (2 * i));
      if ({2'd0, x.sq_rem} >= tr) begin
        y.sq_rem = x.sq_rem - tr[49:0];
        y.root   = x.root | (25'd1 << i);
      end
    end

    if (k == K_DEPTH) begin
      y.depth  = 23'({2'd0, x.it.rsum} - x.root);
      y.nrem_x = {1'b0, abs25(x.it.dx), 16'd0} + {18'd0, x.root[24:1]};
      y.nrem_y = {1'b0, abs25(x.it.dy), 16'd0} + {18'd0, x.root[24:1]};
      y.nq_x   = '0;
      y.nq_y   = '0;
    end

    // Normal components: |d| * 2^16 / dist.
    if (k >= K_ND0 && k < K_ND0 + ND_STEPS) begin
      i  = ND_STEPS - 1 - (k - K_ND0);
      dn = {17'd0, x.root} << i;
      if (x.nrem_x >= dn) begin
        y.nrem_x = x.nrem_x - dn;
        y.nq_x   = x.nq_x | (17'd1 << i);
      end
      if (x.nrem_y >= dn) begin
        y.nrem_y = x.nrem_y - dn;
        y.nq_y   = x.nq_y | (17'd1 << i);
      end
    end

    if (k == K_SHMUL) begin
      y.srem_a = {25'd0, x.depth} * {24'd0, x.it.wa};
      y.srem_b = {25'd0, x.depth} * {24'd0, x.it.wb};
    end

    if (k == K_SHINIT) begin
      y.srem_a = x.srem_a + {24'd0, x.it.wsum[24:1]};
      y.srem_b = x.srem_b + {24'd0, x.it.wsum[24:1]};
      y.shq_a  = '0;
      y.shq_b  = '0;
    end

    // Penetration shares: depth * w / wsum.
    if (k >= K_SD0 && k < K_SD0 + SD_STEPS) begin
      i  = SD_STEPS - 1 - (k - K_SD0);
      ds = {23'd0, x.it.wsum} << i;
      if (x.srem_a >= ds) begin
        y.srem_a = x.srem_a - ds;
        y.shq_a  = x.shq_a | (23'd1 << i);
      end
      if (x.srem_b >= ds) begin
        y.srem_b = x.srem_b - ds;
        y.shq_b  = x.shq_b | (23'd1 << i);
      end
    end

    if (k == K_NFIN) begin
      if (x.root == '0) begin
        y.nx = 18'sd65536;
        y.ny = '0;
      end else begin
        cq   = (x.nq_x > 17'd65536) ? 17'd65536 : x.nq_x;
        y.nx = x.it.dx[24] ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
        cq   = (x.nq_y > 17'd65536) ? 17'd65536 : x.nq_y;
        y.ny = x.it.dy[24] ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
      end
    end

    if (k == K_SMUL) begin
      y.sp_x = 43'(x.it.dvx) * 43'(x.nx);
      y.sp_y = 43'(x.it.dvy) * 43'(x.ny);
    end

    if (k == K_SSUM) begin
      y.sfull = 44'(x.sp_x) + 44'(x.sp_y);
    end

    // Impulse magnitude is twice the rounded closing speed when approaching.
    if (k == K_M) begin
      smag = x.sfull[43] ? 44'(-x.sfull) : 44'(x.sfull);
      t    = (smag + 44'd32768) >> 16;
      y.m  = x.sfull[43] ? {t[25:0], 1'b0} : '0;
    end

    if (k == K_KMUL) begin
      y.krem_a = {25'd0, x.m} * {28'd0, x.it.wa};
      y.krem_b = {25'd0, x.m} * {28'd0, x.it.wb};
    end

    if (k == K_KINIT) begin
      y.krem_a = x.krem_a + {28'd0, x.it.wsum[24:1]};
      y.krem_b = x.krem_b + {28'd0, x.it.wsum[24:1]};
      y.kq_a   = '0;
      y.kq_b   = '0;
    end

    if (k >= K_KD0 && k < K_KD0 + KD_STEPS) begin
      i  = KD_STEPS - 1 - (k - K_KD0);
      dk = {27'd0, x.it.wsum} << i;
      if (x.krem_a >= dk) begin
        y.krem_a = x.krem_a - dk;
        y.kq_a   = x.kq_a | (27'd1 << i);
      end
      if (x.krem_b >= dk) begin
        y.krem_b = x.krem_b - dk;
        y.kq_b   = x.kq_b | (27'd1 << i);
      end
    end

    if (k == K_PMUL) begin
      y.pp_ax = 42'(x.nx) * 42'($signed({1'b0, x.shq_a}));
      y.pp_ay = 42'(x.ny) * 42'($signed({1'b0, x.shq_a}));
      y.pp_bx = 42'(x.nx) * 42'($signed({1'b0, x.shq_b}));
      y.pp_by = 42'(x.ny) * 42'($signed({1'b0, x.shq_b}));
    end

    if (k == K_PADD) begin
      y.npax = 26'(x.it.pax) + 26'(rnd16(46'(x.pp_ax)));
      y.npay = 26'(x.it.pay) + 26'(rnd16(46'(x.pp_ay)));
      y.npbx = 26'(x.it.pbx) - 26'(rnd16(46'(x.pp_bx)));
      y.npby = 26'(x.it.pby) - 26'(rnd16(46'(x.pp_by)));
    end

    if (k == K_VMUL) begin
      y.vp_ax = 46'(x.nx) * 46'($signed({1'b0, x.kq_a}));
      y.vp_ay = 46'(x.ny) * 46'($signed({1'b0, x.kq_a}));
      y.vp_bx = 46'(x.nx) * 46'($signed({1'b0, x.kq_b}));
      y.vp_by = 46'(x.ny) * 46'($signed({1'b0, x.kq_b}));
    end

    // Pairs that are apart, or have no mobile mass, keep their inputs.
    if (k == K_VADD && x.it.resolve) begin
      y.it.pax = sat24(32'(x.npax));
      y.it.pay = sat24(32'(x.npay));
      y.it.pbx = sat24(32'(x.npbx));
      y.it.pby = sat24(32'(x.npby));
      y.it.vax = sat24(32'(x.it.vax) + 32'(rnd16(x.vp_ax)));
      y.it.vay = sat24(32'(x.it.vay) + 32'(rnd16(x.vp_ay)));
      y.it.vbx = sat24(32'(x.it.vbx) - 32'(rnd16(x.vp_bx)));
      y.it.vby = sat24(32'(x.it.vby) - 32'(rnd16(x.vp_by)));
    end
    return y;
  endfunction

  bk_t           st_r [0:N_BACK];
  logic [N_BACK:0] bv_r;
  logic          en;

  assign en        = !bv_r[N_BACK] || out_ready;
  assign q_ready   = en;
  assign out_valid = bv_r[N_BACK];
  assign out_item  = st_r[N_BACK].it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[N_BACK-1:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= bk_load(q_item);
    end
  end

  for (genvar g = 0; g < N_BACK; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1] <= bk_step(g, st_r[g]);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/circle_pair_collision_resolver_top.sv
// Top level of the circle pair collision resolver.
//
// Usage: one disc pair enters on the in_ channel, one resolved pair leaves on
// the out_ channel, both with valid/ready; a transfer happens when valid and
// ready are high at a rising edge. Every input gives exactly one result, in
// order.
// Throughput is one pair per cycle while the output is not stalled. A pair
// passes three front-end stages (differences, squares, contact test), the
// queue, and 79 solver stages set by the 25-stage square root and the chained
// normal, share and impulse dividers, each retiring one quotient bit a stage.
// A four-entry queue sits between the front end and the solver.
// When the receiver holds out_ready low, the solver freezes with its result
// held, the queue fills, and then in_ready falls. Synchronous reset (rst_n
// low) empties the pipeline and the queue; no pair is in flight afterwards.
`default_nettype none

module circle_pair_collision_resolver_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_a_pos_x,
  input  wire logic signed [23:0] in_a_pos_y,
  input  wire logic signed [23:0] in_a_vel_x,
  input  wire logic signed [23:0] in_a_vel_y,
  input  wire logic        [23:0] in_a_inv_mass,
  input  wire logic        [21:0] in_a_radius,
  input  wire logic signed [23:0] in_b_pos_x,
  input  wire logic signed [23:0] in_b_pos_y,
  input  wire logic signed [23:0] in_b_vel_x,
  input  wire logic signed [23:0] in_b_vel_y,
  input  wire logic        [23:0] in_b_inv_mass,
  input  wire logic        [21:0] in_b_radius,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_new_a_pos_x,
  output logic signed [23:0]      out_new_a_pos_y,
  output logic signed [23:0]      out_new_a_vel_x,
  output logic signed [23:0]      out_new_a_vel_y,
  output logic signed [23:0]      out_new_b_pos_x,
  output logic signed [23:0]      out_new_b_pos_y,
  output logic signed [23:0]      out_new_b_vel_x,
  output logic signed [23:0]      out_new_b_vel_y,
  output logic                    out_contact,
  output logic        [46:0]      out_impact_energy
);
  import cpcr_pkg::*;

  cpcr_in_t   in_data;
  cpcr_item_t fq_item, qb_item, res_item;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;

  always_comb begin
    in_data.a_pos_x    = in_a_pos_x;
    in_data.a_pos_y    = in_a_pos_y;
    in_data.a_vel_x    = in_a_vel_x;
    in_data.a_vel_y    = in_a_vel_y;
    in_data.a_inv_mass = in_a_inv_mass;
    in_data.a_radius   = in_a_radius;
    in_data.b_pos_x    = in_b_pos_x;
    in_data.b_pos_y    = in_b_pos_y;
    in_data.b_vel_x    = in_b_vel_x;
    in_data.b_vel_y    = in_b_vel_y;
    in_data.b_inv_mass = in_b_inv_mass;
    in_data.b_radius   = in_b_radius;
  end

  cpcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  cpcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  cpcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (res_item)
  );

  assign out_new_a_pos_x   = res_item.pax;
  assign out_new_a_pos_y   = res_item.pay;
  assign out_new_a_vel_x   = res_item.vax;
  assign out_new_a_vel_y   = res_item.vay;
  assign out_new_b_pos_x   = res_item.pbx;
  assign out_new_b_pos_y   = res_item.pby;
  assign out_new_b_vel_x   = res_item.vbx;
  assign out_new_b_vel_y   = res_item.vby;
  assign out_contact       = res_item.contact;
  assign out_impact_energy = res_item.energy;

`ifndef SYNTHESIS
  a_no_contact_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_contact |-> out_impact_energy == '0)
    else $error("energy reported for a pair without contact");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result present right after reset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_item))
    else $error("result changed while the receiver stalled");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the circle pair collision resolver: random and directed disc pairs.
`timescale 1ns / 1ps

module tb_top;
  import cpcr_pkg::*;

  // One resolved disc pair as the result port shows it.
  typedef struct {
    logic signed [23:0] pax, pay, vax, vay, pbx, pby, vbx, vby;
    logic               contact;
    logic        [46:0] energy;
  } pair_out_t;

  class pair_scoreboard;
    pair_out_t pending[$];
    int        errors;
    int        checked;
    int        contacts;

    function longint rnd_div(longint num, longint den);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function logic signed [23:0] clip24(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function longint clip_norm(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function void note_pair(cpcr_in_t p);
      longint pax, pay, vax, vay, pbx, pby, vbx, vby;
      longint wa, wb, ra, rb, wsum, dx, dy, cdist, depth, nx, ny;
      longint sha, shb, sfull, m, ka, kb;
      logic [63:0] d2, rs2, en;
      pair_out_t r;
      pax = p.a_pos_x; pay = p.a_pos_y; vax = p.a_vel_x; vay = p.a_vel_y;
      pbx = p.b_pos_x; pby = p.b_pos_y; vbx = p.b_vel_x; vby = p.b_vel_y;
      wa = p.a_inv_mass; wb = p.b_inv_mass; ra = p.a_radius; rb = p.b_radius;
      dx = pax - pbx;
      dy = pay - pby;
      d2 = dx * dx + dy * dy;
      rs2 = (ra + rb) * (ra + rb);
      r.contact = d2 <= rs2;
      en = 0;
      if (r.contact) begin
        en = vax * vax + vay * vay + vbx * vbx + vby * vby;
        if (en > 64'h7FFF_FFFF_FFFF) en = 64'h7FFF_FFFF_FFFF;
        wsum = wa + wb;
        if (wsum != 0) begin
          cdist = int_sqrt(d2);
          depth = ra + rb - cdist;
          nx = 65536;
          ny = 0;
          if (cdist != 0) begin
            nx = clip_norm(rnd_div(dx * 65536, cdist));
            ny = clip_norm(rnd_div(dy * 65536, cdist));
          end
          sha = rnd_div(depth * wa, wsum);
          shb = rnd_div(depth * wb, wsum);
          pax += rnd_div(nx * sha, 65536);
          pay += rnd_div(ny * sha, 65536);
          pbx -= rnd_div(nx * shb, 65536);
          pby -= rnd_div(ny * shb, 65536);
          sfull = (vax - vbx) * nx + (vay - vby) * ny;
          if (sfull < 0) begin
            m = -2 * rnd_div(sfull, 65536);
            ka = rnd_div(m * wa, wsum);
            kb = rnd_div(m * wb, wsum);
            vax += rnd_div(nx * ka, 65536);
            vay += rnd_div(ny * ka, 65536);
            vbx -= rnd_div(nx * kb, 65536);
            vby -= rnd_div(ny * kb, 65536);
          end
        end
      end
      r.pax = clip24(pax); r.pay = clip24(pay); r.vax = clip24(vax); r.vay = clip24(vay);
      r.pbx = clip24(pbx); r.pby = clip24(pby); r.vbx = clip24(vbx); r.vby = clip24(vby);
      r.energy = en[46:0];
      pending.push_back(r);
    endfunction

    function void report(string f, longint e, longint a);
      $display("%0t: %s expected %0d, got %0d", $time, f, e, a);
      errors++;
    endfunction

    function void check_result(pair_out_t a);
      pair_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with no pair outstanding", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.contact) contacts++;
      if (a.pax !== e.pax) report("new_a_pos_x", e.pax, a.pax);
      if (a.pay !== e.pay) report("new_a_pos_y", e.pay, a.pay);
      if (a.vax !== e.vax) report("new_a_vel_x", e.vax, a.vax);
      if (a.vay !== e.vay) report("new_a_vel_y", e.vay, a.vay);
      if (a.pbx !== e.pbx) report("new_b_pos_x", e.pbx, a.pbx);
      if (a.pby !== e.pby) report("new_b_pos_y", e.pby, a.pby);
      if (a.vbx !== e.vbx) report("new_b_vel_x", e.vbx, a.vbx);
      if (a.vby !== e.vby) report("new_b_vel_y", e.vby, a.vby);
      if (a.contact !== e.contact) report("contact", e.contact, a.contact);
      if (a.energy !== e.energy) report("impact_energy", e.energy, a.energy);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cpcr_in_t in_pair = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pair_out_t res;
  pair_scoreboard sb;
  logic stim_done = 1'b0;

  always #5 clk = ~clk;

  circle_pair_collision_resolver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_pos_x(in_pair.a_pos_x), .in_a_pos_y(in_pair.a_pos_y),
    .in_a_vel_x(in_pair.a_vel_x), .in_a_vel_y(in_pair.a_vel_y),
    .in_a_inv_mass(in_pair.a_inv_mass), .in_a_radius(in_pair.a_radius),
    .in_b_pos_x(in_pair.b_pos_x), .in_b_pos_y(in_pair.b_pos_y),
    .in_b_vel_x(in_pair.b_vel_x), .in_b_vel_y(in_pair.b_vel_y),
    .in_b_inv_mass(in_pair.b_inv_mass), .in_b_radius(in_pair.b_radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_a_pos_x(res.pax), .out_new_a_pos_y(res.pay),
    .out_new_a_vel_x(res.vax), .out_new_a_vel_y(res.vay),
    .out_new_b_pos_x(res.pbx), .out_new_b_pos_y(res.pby),
    .out_new_b_vel_x(res.vbx), .out_new_b_vel_y(res.vby),
    .out_contact(res.contact), .out_impact_energy(res.energy)
  );

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Presents one pair and holds it until the transfer; valid stays high
  // into the next pair when there is no gap.
  task send_pair(cpcr_in_t p);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_pair <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  function logic [23:0] rnd24();
    return 24'($urandom());
  endfunction

  // Disc pairs that mostly touch: B is offset from A on each axis by at most the radius sum plus 4.
  function cpcr_in_t near_pair(int span);
    cpcr_in_t p;
    int lim;
    p.a_radius = 22'($urandom_range(0, span));
    p.b_radius = 22'($urandom_range(0, span));
    lim = int'(p.a_radius) + int'(p.b_radius) + 4;
    p.a_pos_x = 24'($signed($urandom_range(0, 8000000)) - 4000000);
    p.a_pos_y = 24'($signed($urandom_range(0, 8000000)) - 4000000);
    p.b_pos_x = 24'(p.a_pos_x + $signed($urandom_range(0, 2 * lim)) - lim);
    p.b_pos_y = 24'(p.a_pos_y + $signed($urandom_range(0, 2 * lim)) - lim);
    p.a_vel_x = 24'($signed($urandom_range(0, 200000)) - 100000);
    p.a_vel_y = 24'($signed($urandom_range(0, 200000)) - 100000);
    p.b_vel_x = 24'($signed($urandom_range(0, 200000)) - 100000);
    p.b_vel_y = 24'($signed($urandom_range(0, 200000)) - 100000);
    p.a_inv_mass = $urandom_range(0, 3) == 0 ? rnd24() : 24'($urandom_range(0, 200000));
    p.b_inv_mass = $urandom_range(0, 3) == 0 ? rnd24() : 24'($urandom_range(0, 200000));
    if ($urandom_range(0, 15) == 0) begin
      p.a_vel_x = rnd24(); p.a_vel_y = rnd24(); p.b_vel_x = rnd24(); p.b_vel_y = rnd24();
    end
    return p;
  endfunction

  initial begin
    cpcr_in_t p;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Far apart: no contact, pass through.
    p = '0; p.a_pos_x = 24'sh7FFFFF; p.b_pos_x = 24'sh800000;
    p.a_vel_x = 24'sh800000; p.b_vel_y = 24'sh7FFFFF; p.a_inv_mass = 24'hFFFFFF;
    send_pair(p);
    // Coincident centers take the normal along x.
    p = '0; p.a_radius = 100; p.b_radius = 50; p.a_inv_mass = 65536;
    p.b_inv_mass = 65536; p.a_vel_x = -300; p.b_vel_x = 300;
    send_pair(p);
    // Zero mass sum: only contact and energy.
    p.a_inv_mass = 0; p.b_inv_mass = 0;
    send_pair(p);
    // Energy saturation with full-scale velocities.
    p = '0; p.a_radius = 22'h3FFFFF; p.b_radius = 22'h3FFFFF;
    p.a_vel_x = 24'sh800000; p.a_vel_y = 24'sh800000;
    p.b_vel_x = 24'sh800000; p.b_vel_y = 24'sh800000;
    p.a_inv_mass = 24'hFFFFFF; p.b_inv_mass = 24'hFFFFFF;
    send_pair(p);
    // Exactly touching, then closing head on.
    p = '0; p.a_pos_x = 200; p.a_radius = 100; p.b_radius = 100;
    p.a_inv_mass = 65536; p.b_inv_mass = 32768; p.a_vel_x = -500; p.b_vel_x = 700;
    send_pair(p);
    // Positions at the rails, deep overlap that saturates the correction.
    p = '0; p.a_pos_x = 24'sh7FFFFF; p.a_pos_y = 24'sh7FFFFF;
    p.b_pos_x = 24'sh7FFF00; p.b_pos_y = 24'sh7FFF00;
    p.a_radius = 22'h3FFFFF; p.b_radius = 22'h3FFFFF;
    p.a_inv_mass = 24'hFFFFFF; p.b_inv_mass = 1;
    p.a_vel_x = 24'sh7FFFFF; p.b_vel_x = 24'sh800000;
    send_pair(p);
    // Separating, so no impulse.
    p = '0; p.a_pos_y = 10; p.a_radius = 20; p.b_radius = 20;
    p.a_inv_mass = 1000; p.b_inv_mass = 0; p.a_vel_y = 900;
    send_pair(p);
    // One more touch at the negative rails.
    p.a_pos_x = 24'sh800000; p.b_pos_x = 24'sh800005; p.b_vel_x = 24'sh7FFFFF;
    send_pair(p);

    for (int i = 0; i < 900; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        p = {rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), 22'($urandom()),
             rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), 22'($urandom())};
      end else begin
        p = near_pair($urandom_range(0, 9) == 0 ? 4194303 : 5000);
      end
      send_pair(p);
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver with random stalls.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(res);
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d resolved pairs, %0d of them in contact.", sb.checked, sb.contacts);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("circle_pair_collision_resolver_top verification clean");
    else
      $display("circle_pair_collision_resolver_top verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("circle_pair_collision_resolver_top verification failed");
    $finish;
  end
endmodule
